[sv/fifo_resource_lock_with_timeout_top_assert.svh]
// assertion macros for the resource lock
`ifndef FIFO_RESOURCE_LOCK_WITH_TIMEOUT_TOP_ASSERT_SVH
`define FIFO_RESOURCE_LOCK_WITH_TIMEOUT_TOP_ASSERT_SVH

// same-cycle implication on the block clock
`define FRLT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on the block clock
`define FRLT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/frlt_pkg.sv]
`default_nettype none

package frlt_pkg;

    localparam int ID_W    = 16;
    localparam int KIND_W  = 3;
    localparam int AMT_W   = 16;
    localparam int TICK_W  = 32;
    localparam int WAIT_W  = 5;
    localparam int MODE_W  = 2;

    localparam logic [TICK_W-1:0] TIMEOUT_RST = 32'd1000;

    typedef enum logic [KIND_W-1:0] {
        K_DEP  = 3'd0,
        K_ARR  = 3'd1,
        K_REL  = 3'd2,
        K_GA   = 3'd3,
        K_TICK = 3'd4
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        M_FREE = 2'd0,
        M_DEP  = 2'd1,
        M_ARR  = 2'd2
    } t_mode;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_APPEND,
        S_COMPACT,
        S_TICK_ADD,
        S_TICK_CHK,
        S_PROMOTE,
        S_PROM_DAT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic            arr;
        logic [ID_W-1:0] id;
    } t_entry;

    typedef struct packed {
        logic              done;
        logic              grant_valid;
        logic [ID_W-1:0]   grant_id;
        logic              grant_arr;
        t_mode             mode;
        logic [ID_W-1:0]   owner_id;
        logic [WAIT_W-1:0] waiting;
        logic              dropped;
    } t_status;

endpackage

`default_nettype wire

[sv/frlt_ram.sv]
`default_nettype none

module frlt_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[sv/frlt_ctrl.sv]
`default_nettype none

module frlt_ctrl #(
    parameter int WAIT_DEPTH = 16,
    localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [frlt_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [frlt_pkg::ID_W-1:0]     i_id,
    input  wire logic [frlt_pkg::AMT_W-1:0]    i_amount,
    input  wire logic [frlt_pkg::TICK_W-1:0]   i_timeout,
    output logic                               o_busy,
    output frlt_pkg::t_status                  o_status,
    output logic                               o_ram_we,
    output logic [AW-1:0]                      o_ram_waddr,
    output frlt_pkg::t_entry                   o_ram_wdata,
    output logic [AW-1:0]                      o_ram_raddr,
    input  frlt_pkg::t_entry                   i_ram_rdata
);

    import frlt_pkg::*;

    localparam int CW = $clog2(WAIT_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(WAIT_DEPTH);
    localparam logic [CW:0]   DEPTH_X = (CW+1)'(WAIT_DEPTH);

    t_state            r_state, n_state;
    t_kind             r_kind, n_kind;
    logic [ID_W-1:0]   r_id, n_id;
    logic [AMT_W-1:0]  r_amount, n_amount;
    t_mode             r_mode, n_mode;
    logic [ID_W-1:0]   r_holder, n_holder;
    logic [TICK_W-1:0] r_held, n_held;
    logic [CW-1:0]     r_fill, n_fill;
    logic [AW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_wcnt, n_wcnt;
    logic              r_rd_vld, n_rd_vld;
    logic              r_found, n_found;
    logic              r_gvalid, n_gvalid;
    logic [ID_W-1:0]   r_gid, n_gid;
    logic              r_garr, n_garr;
    logic              r_dropped, n_dropped;

    logic              owner_hit;
    logic              scan_end;
    logic [TICK_W:0]   tick_sum;
    logic [CW+WAIT_W-1:0] fill_ext;

    // circular index into the wait queue
    function automatic logic [AW-1:0] f_idx(input logic [AW-1:0] base,
                                            input logic [CW-1:0] ofs);
        logic [CW:0] sum;
        sum = (CW+1)'(base) + (CW+1)'(ofs);
        if (sum >= DEPTH_X) begin
            sum = sum - DEPTH_X;
        end
        return sum[AW-1:0];
    endfunction

    assign owner_hit = (r_mode != M_FREE) && (r_holder == r_id);
    assign scan_end  = (r_cnt == r_fill) && !r_rd_vld;
    assign tick_sum  = {1'b0, r_held} + (TICK_W+1)'(r_amount);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                case (r_kind)
                    K_TICK: begin
                        n_state = (r_amount != '0 && r_mode != M_FREE) ? S_TICK_ADD : S_DONE;
                    end
                    K_DEP, K_ARR: begin
                        if (r_id == '0 || owner_hit || r_mode == M_FREE) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    K_REL: n_state = (r_id == '0) ? S_DONE : S_PROMOTE;
                    K_GA: n_state = (r_id == '0) ? S_DONE : S_COMPACT;
                    default: n_state = S_DONE;
                endcase
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_APPEND;
                end
            end
            S_APPEND: n_state = S_DONE;
            S_COMPACT: begin
                if (scan_end) begin
                    n_state = S_PROMOTE;
                end
            end
            S_TICK_ADD: n_state = S_TICK_CHK;
            S_TICK_CHK: n_state = (r_held >= i_timeout) ? S_PROMOTE : S_DONE;
            S_PROMOTE: begin
                n_state = (r_mode == M_FREE && r_fill != '0) ? S_PROM_DAT : S_DONE;
            end
            S_PROM_DAT: n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_kind      = r_kind;
        n_id        = r_id;
        n_amount    = r_amount;
        n_mode      = r_mode;
        n_holder    = r_holder;
        n_held      = r_held;
        n_fill      = r_fill;
        n_head      = r_head;
        n_cnt       = r_cnt;
        n_wcnt      = r_wcnt;
        n_rd_vld    = r_rd_vld;
        n_found     = r_found;
        n_gvalid    = r_gvalid;
        n_gid       = r_gid;
        n_garr      = r_garr;
        n_dropped   = r_dropped;
        o_ram_we    = 1'b0;
        o_ram_waddr = f_idx(r_head, r_fill);
        o_ram_wdata = '{arr: (r_kind == K_ARR), id: r_id};
        o_ram_raddr = f_idx(r_head, r_cnt);
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_kind    = t_kind'(i_kind);
                    n_id      = i_id;
                    n_amount  = i_amount;
                    n_gvalid  = 1'b0;
                    n_gid     = '0;
                    n_garr    = 1'b0;
                    n_dropped = 1'b0;
                    n_found   = 1'b0;
                    n_cnt     = '0;
                    n_wcnt    = '0;
                    n_rd_vld  = 1'b0;
                end
            end
            S_DECODE: begin
                case (r_kind)
                    K_DEP, K_ARR: begin
                        if (r_id != '0) begin
                            if (owner_hit) begin
                                n_gvalid = 1'b1;
                                n_gid    = r_id;
                                n_garr   = (r_kind == K_ARR);
                            end else if (r_mode == M_FREE) begin
                                n_mode   = (r_kind == K_ARR) ? M_ARR : M_DEP;
                                n_holder = r_id;
                                n_held   = '0;
                                n_gvalid = 1'b1;
                                n_gid    = r_id;
                                n_garr   = (r_kind == K_ARR);
                            end
                        end
                    end
                    K_REL: begin
                        if (r_id != '0 && owner_hit) begin
                            n_mode   = M_FREE;
                            n_holder = '0;
                        end
                    end
                    K_GA: begin
                        if (r_id != '0 && r_mode == M_ARR && r_holder == r_id) begin
                            n_mode   = M_FREE;
                            n_holder = '0;
                        end
                    end
                    default: begin
                        n_mode = r_mode;
                    end
                endcase
            end
            S_SCAN: begin
                n_rd_vld = (r_cnt < r_fill);
                if (r_cnt < r_fill) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_rd_vld && i_ram_rdata.id == r_id) begin
                    n_found = 1'b1;
                end
            end
            S_APPEND: begin
                if (!r_found) begin
                    if (r_fill >= DEPTH_C) begin
                        n_dropped = 1'b1;
                    end else begin
                        o_ram_we = 1'b1;
                        n_fill   = r_fill + 1'b1;
                    end
                end
            end
            S_COMPACT: begin
                n_rd_vld    = (r_cnt < r_fill);
                o_ram_waddr = f_idx(r_head, r_wcnt);
                o_ram_wdata = i_ram_rdata;
                if (r_cnt < r_fill) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_rd_vld && i_ram_rdata.id != r_id) begin
                    o_ram_we = 1'b1;
                    n_wcnt   = r_wcnt + 1'b1;
                end
                if (scan_end) begin
                    n_fill = r_wcnt;
                end
            end
            S_TICK_ADD: begin
                n_held = tick_sum[TICK_W] ? '1 : tick_sum[TICK_W-1:0];
            end
            S_TICK_CHK: begin
                if (r_held >= i_timeout) begin
                    n_mode   = M_FREE;
                    n_holder = '0;
                end
            end
            S_PROMOTE: begin
                o_ram_raddr = r_head;
            end
            S_PROM_DAT: begin
                n_mode   = i_ram_rdata.arr ? M_ARR : M_DEP;
                n_holder = i_ram_rdata.id;
                n_held   = '0;
                n_gvalid = 1'b1;
                n_gid    = i_ram_rdata.id;
                n_garr   = i_ram_rdata.arr;
                n_head   = f_idx(r_head, CW'(1));
                n_fill   = r_fill - 1'b1;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= M_FREE;
            r_holder <= '0;
            r_held   <= '0;
            r_fill   <= '0;
            r_head   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_holder <= n_holder;
            r_held   <= n_held;
            r_fill   <= n_fill;
            r_head   <= n_head;
            r_rd_vld <= n_rd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_id      <= n_id;
        r_amount  <= n_amount;
        r_cnt     <= n_cnt;
        r_wcnt    <= n_wcnt;
        r_found   <= n_found;
        r_gvalid  <= n_gvalid;
        r_gid     <= n_gid;
        r_garr    <= n_garr;
        r_dropped <= n_dropped;
    end

    assign fill_ext = {{WAIT_W{1'b0}}, r_fill};
    assign o_busy   = (r_state != S_IDLE);

    always_comb begin
        o_status.done        = (r_state == S_DONE);
        o_status.grant_valid = r_gvalid;
        o_status.grant_id    = r_gid;
        o_status.grant_arr   = r_garr;
        o_status.mode        = r_mode;
        o_status.owner_id    = r_holder;
        o_status.waiting     = fill_ext[WAIT_W-1:0];
        o_status.dropped     = r_dropped;
    end

endmodule

`default_nettype wire

[sv/fifo_resource_lock_with_timeout_top.sv]
// channel   | handshake           | payload
// ----------+---------------------+------------------------------------------
// command   | start / busy        | i_kind, i_requester_id, i_tick_amount
// result    | o_done (strobe)     | o_grant_*, o_owner_*, o_waiting_count,
//           |                     | o_request_dropped
// config    | i_cfg_we            | i_cfg_wdata (hold timeout in ticks)
//
// the wait queue lives in one ram and is scanned one entry a cycle
// o_done is high for one cycle; the receiver cannot stall it
// busy stays high from the cycle after start until o_done has been shown
// synchronous active-low reset frees the resource and empties the queue

`default_nettype none

module fifo_resource_lock_with_timeout_top #(
    parameter int WAIT_DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [frlt_pkg::KIND_W-1:0]   i_kind,
    input  wire logic [frlt_pkg::ID_W-1:0]     i_requester_id,
    input  wire logic [frlt_pkg::AMT_W-1:0]    i_tick_amount,
    input  wire logic                          i_cfg_we,
    input  wire logic [frlt_pkg::TICK_W-1:0]   i_cfg_wdata,
    output logic                               o_done,
    output logic                               o_grant_valid,
    output logic [frlt_pkg::ID_W-1:0]          o_grant_id,
    output logic                               o_grant_is_arrival,
    output logic [frlt_pkg::MODE_W-1:0]        o_owner_mode,
    output logic [frlt_pkg::ID_W-1:0]          o_owner_id,
    output logic [frlt_pkg::WAIT_W-1:0]        o_waiting_count,
    output logic                               o_request_dropped
);

    import frlt_pkg::*;

    localparam int AW = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    logic [TICK_W-1:0] r_timeout;
    t_status           status;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    t_entry            ram_wdata;
    t_entry            ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            r_timeout <= i_cfg_wdata;
        end
    end

    frlt_ctrl #(
        .WAIT_DEPTH (WAIT_DEPTH)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_kind      (i_kind),
        .i_id        (i_requester_id),
        .i_amount    (i_tick_amount),
        .i_timeout   (r_timeout),
        .o_busy      (busy),
        .o_status    (status),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    frlt_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_done             = status.done;
    assign o_grant_valid      = status.grant_valid;
    assign o_grant_id         = status.grant_id;
    assign o_grant_is_arrival = status.grant_arr;
    assign o_owner_mode       = status.mode;
    assign o_owner_id         = status.owner_id;
    assign o_waiting_count    = status.waiting;
    assign o_request_dropped  = status.dropped;

endmodule

`default_nettype wire

[sv/frlt_checker.sv]
`default_nettype none

`include "fifo_resource_lock_with_timeout_top_assert.svh"

module frlt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire logic [frlt_pkg::KIND_W-1:0]   i_kind,
    input wire logic [frlt_pkg::ID_W-1:0]     i_requester_id,
    input wire logic [frlt_pkg::AMT_W-1:0]    i_tick_amount,
    input wire logic                          i_cfg_we,
    input wire logic [frlt_pkg::TICK_W-1:0]   i_cfg_wdata,
    input wire logic                          o_done,
    input wire logic                          o_grant_valid,
    input wire logic [frlt_pkg::ID_W-1:0]     o_grant_id,
    input wire logic                          o_grant_is_arrival,
    input wire logic [frlt_pkg::MODE_W-1:0]   o_owner_mode,
    input wire logic [frlt_pkg::ID_W-1:0]     o_owner_id,
    input wire logic [frlt_pkg::WAIT_W-1:0]   o_waiting_count,
    input wire logic                          o_request_dropped
);

    import frlt_pkg::*;

    logic grant_clear;
    logic owner_match;

    assign grant_clear = (o_grant_id == '0) && !o_grant_is_arrival;
    // free resource and zero owner go together
    assign owner_match = (o_owner_mode == M_FREE) == (o_owner_id == '0);

    // a transfer on the command side always makes the block busy
    `FRLT_ASSERT_NEXT(a_busy_after_start, start && !busy, busy, "busy low after start")

    `FRLT_ASSERT_SAME(a_done_while_busy, o_done, busy, "result outside a command")

    `FRLT_ASSERT_NEXT(a_done_single, o_done, !o_done, "result strobe longer than one cycle")

    `FRLT_ASSERT_SAME(a_no_grant_clean, o_done && !o_grant_valid, grant_clear, "stray grant")

    `FRLT_ASSERT_SAME(a_owner_consistent, o_done, owner_match, "owner id and mode disagree")

endmodule

bind fifo_resource_lock_with_timeout_top frlt_checker u_frlt_checker (.*);

`default_nettype wire
